[rtl/core/tve_pkg.sv]
`timescale 1ns / 1ps

package tve_pkg;

    // Name and window geometry
    localparam int MAX_TAG_CHARS = 16;
    localparam int WIN_DEPTH     = MAX_TAG_CHARS + 2;
    localparam int LEN_W         = 5;
    localparam int NAME_W        = 8 * MAX_TAG_CHARS;
    localparam int NAME_IDX_W    = $clog2(MAX_TAG_CHARS);

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN  = 2'd2;

    localparam logic [LEN_W-1:0] NAME_LEN_RESET = 5'd1;
    localparam logic [LEN_W-1:0] NAME_LEN_MIN   = 5'd1;
    localparam logic [LEN_W-1:0] NAME_LEN_MAX   = LEN_W'(MAX_TAG_CHARS);

    // Characters with special meaning
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Status carried with the last result
    localparam logic ST_FOUND     = 1'b0;
    localparam logic ST_NOT_FOUND = 1'b1;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam logic [QCNT_W-1:0] QUEUE_SPACE_LIMIT = QCNT_W'(QUEUE_DEPTH - 2);

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_EMIT   = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] name_low;
        logic [CFG_DATA_W-1:0] name_high;
        logic [LEN_W-1:0]      name_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic       status;
    } result_t;

    // Up to two results per processed item
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

[rtl/core/tve_cfg_regs.sv]
`timescale 1ns / 1ps

module tve_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tve_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tve_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tve_pkg::CFG_DATA_W-1:0]   prdata,
    output tve_pkg::cfg_t                    cfg
);

    logic [tve_pkg::CFG_DATA_W-1:0] name_low_reg;
    logic [tve_pkg::CFG_DATA_W-1:0] name_high_reg;
    logic [tve_pkg::LEN_W-1:0]      name_len_reg;
    logic [tve_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;

    // Registers sit at 8-byte strides
    assign reg_idx = paddr[tve_pkg::CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_low_reg  <= '0;
            name_high_reg <= '0;
            name_len_reg  <= tve_pkg::NAME_LEN_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                tve_pkg::REG_NAME_LOW:  name_low_reg  <= pwdata;
                tve_pkg::REG_NAME_HIGH: name_high_reg <= pwdata;
                tve_pkg::REG_NAME_LEN:  name_len_reg  <= pwdata[tve_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            tve_pkg::REG_NAME_LOW:  prdata = name_low_reg;
            tve_pkg::REG_NAME_HIGH: prdata = name_high_reg;
            tve_pkg::REG_NAME_LEN:  prdata = tve_pkg::CFG_DATA_W'(name_len_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.name_low  = name_low_reg;
    assign cfg.name_high = name_high_reg;
    assign cfg.name_len  = name_len_reg;

endmodule

[rtl/core/tve_matcher.sv]
`timescale 1ns / 1ps

module tve_matcher (
    input  logic          aclk,
    input  logic          aresetn,
    input  tve_pkg::cfg_t cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          space_ok,
    output tve_pkg::push_t push
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    logic       fire;

    // Search / emit state
    tve_pkg::phase_t phase_reg, phase_next;
    logic            held_reg, held_next;
    logic [7:0]      win_reg [tve_pkg::WIN_DEPTH];
    logic            shift_en;
    logic            clear_en;

    // Pattern compare
    logic [tve_pkg::LEN_W-1:0]      name_n;
    logic [tve_pkg::NAME_W-1:0]     name_bits;
    logic [7:0]                     name_chr [tve_pkg::MAX_TAG_CHARS];
    logic [tve_pkg::LEN_W-1:0]      pos_diff [tve_pkg::WIN_DEPTH];
    logic [tve_pkg::WIN_DEPTH-1:1]  pos_ok;
    logic                           win_match;
    logic                           is_term;

    assign fire     = in_valid_reg && space_ok;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    // Length clamped to 1..MAX_TAG_CHARS
    always_comb begin
        if (cfg.name_len < tve_pkg::NAME_LEN_MIN) begin
            name_n = tve_pkg::NAME_LEN_MIN;
        end else if (cfg.name_len > tve_pkg::NAME_LEN_MAX) begin
            name_n = tve_pkg::NAME_LEN_MAX;
        end else begin
            name_n = cfg.name_len;
        end
    end

    assign name_bits = {cfg.name_high, cfg.name_low};

    always_comb begin
        for (int i = 0; i < tve_pkg::MAX_TAG_CHARS; i++) begin
            name_chr[i] = name_bits[8*i +: 8];
        end
    end

    // Window after the shift: position 0 is the new char, position p is win_reg[p-1].
    // Position p (1..n) must hold name char n-p, position n+1 must hold '<'.
    always_comb begin
        pos_diff[0] = '0;
        for (int p = 1; p < tve_pkg::WIN_DEPTH; p++) begin
            pos_diff[p] = name_n - tve_pkg::LEN_W'(p);
            if (tve_pkg::LEN_W'(p) <= name_n) begin
                pos_ok[p] = (win_reg[p-1] == name_chr[pos_diff[p][tve_pkg::NAME_IDX_W-1:0]]);
            end else if (tve_pkg::LEN_W'(p) == name_n + 1'b1) begin
                pos_ok[p] = (win_reg[p-1] == tve_pkg::CH_LT);
            end else begin
                pos_ok[p] = 1'b1;
            end
        end
    end

    assign win_match = (in_char_reg == tve_pkg::CH_GT) && (&pos_ok);
    assign is_term   = (in_char_reg == tve_pkg::CH_LT) || (in_char_reg == tve_pkg::CH_LF) ||
                       (in_char_reg == tve_pkg::CH_CR);

    // Per-item decision
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        shift_en   = 1'b0;
        clear_en   = 1'b0;
        push       = '0;
        if (fire) begin
            if (in_end_reg) begin
                clear_en   = 1'b1;
                phase_next = tve_pkg::PH_SEARCH;
                held_next  = 1'b0;
                if ((phase_reg == tve_pkg::PH_EMIT) && held_reg) begin
                    push.cnt          = 2'd2;
                    push.r0.out_byte  = tve_pkg::CH_BSL;
                    push.r1.is_last   = 1'b1;
                    push.r1.status    = tve_pkg::ST_FOUND;
                end else begin
                    push.cnt        = 2'd1;
                    push.r0.is_last = 1'b1;
                    push.r0.status  = (phase_reg == tve_pkg::PH_SEARCH) ?
                                      tve_pkg::ST_NOT_FOUND : tve_pkg::ST_FOUND;
                end
            end else begin
                case (phase_reg)
                    tve_pkg::PH_SEARCH: begin
                        shift_en = 1'b1;
                        if (win_match) begin
                            phase_next = tve_pkg::PH_EMIT;
                            held_next  = 1'b0;
                        end
                    end
                    tve_pkg::PH_EMIT: begin
                        if (held_reg && (in_char_reg == tve_pkg::CH_LT)) begin
                            // escaped '<' goes out as data
                            held_next        = 1'b0;
                            push.cnt         = 2'd1;
                            push.r0.out_byte = tve_pkg::CH_LT;
                        end else begin
                            if (held_reg) begin
                                held_next        = 1'b0;
                                push.cnt         = 2'd1;
                                push.r0.out_byte = tve_pkg::CH_BSL;
                            end
                            if (is_term) begin
                                phase_next = tve_pkg::PH_DONE;
                            end else if (in_char_reg == tve_pkg::CH_BSL) begin
                                held_next = 1'b1;
                            end else if (held_reg) begin
                                push.cnt         = 2'd2;
                                push.r1.out_byte = in_char_reg;
                            end else begin
                                push.cnt         = 2'd1;
                                push.r0.out_byte = in_char_reg;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tve_pkg::PH_SEARCH;
            held_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // Sliding window, newest char in entry 0
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_en) begin
            for (int i = 0; i < tve_pkg::WIN_DEPTH; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift_en) begin
            win_reg[0] <= in_char_reg;
            for (int i = 1; i < tve_pkg::WIN_DEPTH; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

endmodule

[rtl/core/tve_out_queue.sv]
`timescale 1ns / 1ps

module tve_out_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  tve_pkg::push_t push,
    output logic           space_ok,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);

    tve_pkg::result_t                entries_reg [tve_pkg::QUEUE_DEPTH];
    logic [tve_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tve_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tve_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            pop;
    tve_pkg::result_t                head;

    // Room for two results, from registered state only
    assign space_ok = (count_reg <= tve_pkg::QUEUE_SPACE_LIMIT);

    assign head     = entries_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.out_byte;
    assign m_tlast  = head.is_last;
    assign m_tuser  = head.status;
    assign pop      = m_tvalid && m_tready;

    assign wr_ptr_next = wr_ptr_reg + tve_pkg::QPTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + tve_pkg::QPTR_W'(pop);
    assign count_next  = count_reg + tve_pkg::QCNT_W'(push.cnt) - tve_pkg::QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            entries_reg[wr_ptr_reg + 1'b1] <= push.r1;
        end
    end

endmodule

[rtl/core/tag_value_extractor_unit.sv]
`timescale 1ns / 1ps

// Tag value extractor.
// Input stream (s_*): one character per transfer in s_tdata; s_tlast high marks
// the end of a string and the transfer carries no character.
// Output stream (m_*): one value character per transfer in m_tdata. A transfer
// with m_tlast high closes the string and carries the status in m_tuser
// (0 tag found, 1 tag not found), with m_tdata zero.
// The tag name and its length are set over the APB port (name low word at 0x00,
// high word at 0x08, length at 0x10); the user must set them only while no
// string is in flight, which the block itself does not enforce. A character
// passes the input register, then the result queue, which drives m_* directly.
// Throughput: one character per cycle unless s_tready drops; the input register feeds
// one pass of window compare and emit logic, whose results land in a four-entry
// result queue, both results of an item (a released backslash plus a character)
// at once. The queue drains one result per cycle while m_tready is high. If the
// receiver stalls, the queue fills and s_tready drops while an item waits in the
// input register and fewer than two queue entries are free; nothing is lost.
// Reset clears the window, the search state and the queue, and returns the
// name registers to all-zero name bytes with a length of one.
module tag_value_extractor_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] char_in
    input  logic                           s_tlast,   // is_end
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,   // is_last
    output logic                           m_tuser,   // [0] status
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tve_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tve_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tve_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    tve_pkg::cfg_t  cfg;
    tve_pkg::push_t push;
    logic           space_ok;

    assign pready = 1'b1;

    tve_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tve_matcher u_matcher (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .space_ok (space_ok),
        .push     (push)
    );

    tve_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/tve_checker.sv]
`timescale 1ns / 1ps

module tve_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser,
    input logic       pready
);

    // Nothing left in the result queue right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Closing transfer carries no character
    a_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata == 8'h00))
        else $error("last result carries a character");

    // Data transfers carry no status
    a_data_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser == 1'b0))
        else $error("data result carries a status");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

    // Config port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind tag_value_extractor_unit tve_checker u_tve_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
